FILE: rtl/kwsms_pkg.sv
// ----------------------------------------------------------------------------
// kwsms_pkg
// Shared constants and types for the K-weighted sliding mean-square block.
// ----------------------------------------------------------------------------
package kwsms_pkg;

	localparam int RING_DEPTH  = 32768;
	localparam int PTR_W       = $clog2(RING_DEPTH);
	localparam int SAMPLE_BITS = 24;
	localparam int COEF_W      = 32;
	localparam int FRAC_BITS   = 28;
	localparam int SQ_W        = 2 * SAMPLE_BITS;
	localparam int SUM_W       = 63;
	localparam int WLEN_W      = 15;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int ACC_W       = 64;
	localparam int OPND_W      = SAMPLE_BITS + 1;
	localparam int PROD_W      = COEF_W + OPND_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LENGTH = 3'd0,
		REG_SHELF_B0      = 3'd1,
		REG_SHELF_B1      = 3'd2,
		REG_SHELF_B2      = 3'd3,
		REG_SHELF_A1      = 3'd4,
		REG_SHELF_A2      = 3'd5,
		REG_HIGHPASS_A1   = 3'd6,
		REG_HIGHPASS_A2   = 3'd7
	} reg_idx_t;

	// fixed high pass feedforward taps, Q3.28
	localparam logic signed [COEF_W-1:0] HP_B0 = 32'sd268435456;
	localparam logic signed [COEF_W-1:0] HP_B1 = -32'sd536870912;
	localparam logic signed [COEF_W-1:0] HP_B2 = 32'sd268435456;

	// queue to engine handshake
	typedef struct packed {
		logic                          valid;
		logic signed [SAMPLE_BITS-1:0] sample;
	} q_head_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} eng_status_t;

endpackage

FILE: rtl/kweighted_sliding_mean_square.sv
// ----------------------------------------------------------------------------
// kweighted_sliding_mean_square
// K-weighting filter pair with a sliding sum of squares over a window.
// ----------------------------------------------------------------------------
// Each transfer on the input channel carries one signed 24-bit sample and
// yields one result: the K-weighted sample and the sum of its square with the
// squares of the previous window_length-1 weighted samples. The engine takes
// one item at a time: it picks the next sample, forms ten filter products
// through one shared 32x25 multiplier (five per biquad, each biquad followed
// by a rounding step), squares the result, then updates the ring and sum.
// A two-entry input queue and the output register keep both sides decoupled.
// After reset the 32768-entry square ring is cleared, one entry a cycle, so
// the input stalls meanwhile; configuration writes are taken anyway.
// Writing window_length clears the running sum and keeps the ring.
module kweighted_sliding_mean_square import kwsms_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] audio_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [SUM_W-1:0]              window_sum,
	output logic signed [SAMPLE_BITS-1:0] weighted_sample
);

	q_head_t     head;
	eng_status_t status;

	// front: input transfer and queue
	kwsms_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.audio_in (audio_in),
		.status   (status),
		.head     (head)
	);

	// back: filters, square, ring and output register
	kwsms_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.head            (head),
		.status          (status),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.window_sum      (window_sum),
		.weighted_sample (weighted_sample)
	);

endmodule

FILE: rtl/kwsms_front.sv
// ----------------------------------------------------------------------------
// kwsms_front
// Input side: accepts samples into a two-entry queue ahead of the engine.
// ----------------------------------------------------------------------------
module kwsms_front import kwsms_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] audio_in,
	input  eng_status_t                   status,
	output q_head_t                       head
);

	logic signed [SAMPLE_BITS-1:0] data_q [2];
	logic [1:0]                    cnt_q;
	logic                          push;
	logic                          pop;
	logic                          push_head;

	assign in_stall = (cnt_q == 2'd2) || status.clearing;
	assign push     = in_valid && !in_stall;
	assign pop      = status.pop && (cnt_q != 2'd0);

	// new transfer lands in the head slot when the queue is, or becomes, empty
	assign push_head = push && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop));

	assign head.valid  = (cnt_q != 2'd0);
	assign head.sample = data_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push_head) begin
			data_q[0] <= audio_in;
		end else if (pop) begin
			data_q[0] <= data_q[1];
		end
		if (push && !push_head) begin
			data_q[1] <= audio_in;
		end
	end

endmodule

FILE: rtl/kwsms_back.sv
// ----------------------------------------------------------------------------
// kwsms_back
// Engine: two biquads on one shared multiplier, square, ring and window sum.
// ----------------------------------------------------------------------------
module kwsms_back import kwsms_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  q_head_t                       head,
	output eng_status_t                   status,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [SUM_W-1:0]              window_sum,
	output logic signed [SAMPLE_BITS-1:0] weighted_sample
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MAC  = 5'b00010,
		ST_RND  = 5'b00100,
		ST_SQ   = 5'b01000,
		ST_UPD  = 5'b10000
	} state_t;

	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	state_t state_q;
	logic [2:0] k_q;
	logic       stg_q;

	logic [WLEN_W-1:0]        wlen_q;
	logic signed [COEF_W-1:0] coef_q [1:7];

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] h1_q [4];
	logic signed [SAMPLE_BITS-1:0] h2_q [4];
	logic signed [SAMPLE_BITS-1:0] s2_q;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic [SQ_W-1:0]          sq_q;
	logic [SUM_W-1:0]         sum_q;
	logic [PTR_W-1:0]         wp_q;

	logic [PTR_W-1:0] clr_q;
	logic             clearing_q;

	logic [SQ_W-1:0] ring [RING_DEPTH];
	logic [SQ_W-1:0] rdata_q;
	logic            mem_we;
	logic [PTR_W-1:0] mem_waddr;
	logic [SQ_W-1:0]  mem_wdata;
	logic [PTR_W-1:0] rd_addr;

	logic signed [COEF_W-1:0] c_sel;
	logic signed [OPND_W-1:0] o_sel;
	logic signed [SAMPLE_BITS-1:0] hx0, hx1, hy0, hy1;
	logic signed [ACC_W-1:0]  rnd_full;
	logic signed [SAMPLE_BITS-1:0] rnd_sat;
	logic [SQ_W-1:0]  old_sq;
	logic             upd_go;

	logic out_valid_q;
	logic [SUM_W-1:0] out_sum_q;
	logic signed [SAMPLE_BITS-1:0] out_smp_q;

	assign out_valid       = out_valid_q;
	assign window_sum      = out_sum_q;
	assign weighted_sample = out_smp_q;

	assign status.clearing = clearing_q;
	assign status.pop      = (state_q == ST_IDLE) && head.valid && !clearing_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q    <= 15'd19200;
			coef_q[1] <= 32'sd412081942;
			coef_q[2] <= -32'sd722546693;
			coef_q[3] <= 32'sd321691120;
			coef_q[4] <= -32'sd453832900;
			coef_q[5] <= 32'sd196623809;
			coef_q[6] <= -32'sd534199295;
			coef_q[7] <= 32'sd265770496;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_WINDOW_LENGTH: wlen_q <= cfg_data[WLEN_W-1:0];
				REG_SHELF_B0:      coef_q[1] <= cfg_data;
				REG_SHELF_B1:      coef_q[2] <= cfg_data;
				REG_SHELF_B2:      coef_q[3] <= cfg_data;
				REG_SHELF_A1:      coef_q[4] <= cfg_data;
				REG_SHELF_A2:      coef_q[5] <= cfg_data;
				REG_HIGHPASS_A1:   coef_q[6] <= cfg_data;
				REG_HIGHPASS_A2:   coef_q[7] <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand select for the shared multiplier
	assign hx0 = stg_q ? h2_q[0] : h1_q[0];
	assign hx1 = stg_q ? h2_q[1] : h1_q[1];
	assign hy0 = stg_q ? h2_q[2] : h1_q[2];
	assign hy1 = stg_q ? h2_q[3] : h1_q[3];

	always_comb begin
		c_sel = '0;
		o_sel = '0;
		case (k_q)
			3'd0: begin
				c_sel = stg_q ? HP_B0 : coef_q[1];
				o_sel = OPND_W'(x_q);
			end
			3'd1: begin
				c_sel = stg_q ? HP_B1 : coef_q[2];
				o_sel = OPND_W'(hx0);
			end
			3'd2: begin
				c_sel = stg_q ? HP_B2 : coef_q[3];
				o_sel = OPND_W'(hx1);
			end
			3'd3: begin
				c_sel = stg_q ? coef_q[6] : coef_q[4];
				o_sel = -OPND_W'(hy0);
			end
			3'd4: begin
				c_sel = stg_q ? coef_q[7] : coef_q[5];
				o_sel = -OPND_W'(hy1);
			end
			default: ;
		endcase
	end

	// round half up, then saturate
	assign rnd_full = (acc_q + (ACC_W'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;
	always_comb begin
		if (rnd_full > ACC_W'(S_MAX)) begin
			rnd_sat = S_MAX;
		end else if (rnd_full < ACC_W'(S_MIN)) begin
			rnd_sat = S_MIN;
		end else begin
			rnd_sat = rnd_full[SAMPLE_BITS-1:0];
		end
	end

	assign rd_addr = wp_q - wlen_q[PTR_W-1:0];
	assign old_sq  = (wlen_q[PTR_W-1:0] == '0) ? sq_q : rdata_q;
	assign upd_go  = (state_q == ST_UPD) && (!out_valid_q || !out_stall);

	assign mem_we    = clearing_q || upd_go;
	assign mem_waddr = clearing_q ? clr_q : wp_q;
	assign mem_wdata = clearing_q ? '0 : sq_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring[mem_waddr] <= mem_wdata;
		end
		rdata_q <= ring[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			stg_q       <= 1'b0;
			clr_q       <= '0;
			clearing_q  <= 1'b1;
			wp_q        <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				h1_q[i] <= '0;
				h2_q[i] <= '0;
			end
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == PTR_W'(RING_DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (out_valid_q && !out_stall && !upd_go) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we && reg_idx_t'(cfg_index) == REG_WINDOW_LENGTH) begin
				sum_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (status.pop) begin
						stg_q   <= 1'b0;
						k_q     <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					k_q <= k_q + 1'b1;
					if (k_q == 3'd5) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					if (!stg_q) begin
						h1_q[1] <= h1_q[0];
						h1_q[0] <= x_q;
						h1_q[3] <= h1_q[2];
						h1_q[2] <= rnd_sat;
						stg_q   <= 1'b1;
						k_q     <= '0;
						state_q <= ST_MAC;
					end else begin
						h2_q[1] <= h2_q[0];
						h2_q[0] <= x_q;
						h2_q[3] <= h2_q[2];
						h2_q[2] <= rnd_sat;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_go) begin
						sum_q       <= sum_q - SUM_W'(old_sq) + SUM_W'(sq_q);
						wp_q        <= wp_q + 1'b1;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (status.pop) begin
			x_q <= head.sample;
		end
		if (state_q == ST_MAC) begin
			prod_s1 <= PROD_W'(c_sel) * PROD_W'(o_sel);
			if (k_q == 3'd0) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
		if (state_q == ST_RND) begin
			x_q  <= rnd_sat;
			s2_q <= rnd_sat;
		end
		if (state_q == ST_SQ) begin
			sq_q <= SQ_W'(s2_q * s2_q);
		end
		if (upd_go) begin
			out_sum_q <= sum_q - SUM_W'(old_sq) + SUM_W'(sq_q);
			out_smp_q <= s2_q;
		end
	end

endmodule

FILE: rtl/kwsms_checker.sv
// ----------------------------------------------------------------------------
// kwsms_checker
// Port-level checks on the top level, attached by bind.
// ----------------------------------------------------------------------------
module kwsms_checker import kwsms_pkg::*; (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [SUM_W-1:0]              window_sum,
	input logic signed [SAMPLE_BITS-1:0] weighted_sample
);

	logic [2:0] pend_q;
	logic       in_x;
	logic       out_x;

	assign in_x  = in_valid && !in_stall;
	assign out_x = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {2'b0, in_x} - {2'b0, out_x};
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(window_sum) && $stable(weighted_sample))
		else $error("stalled result changed");

	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("result without a sample");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("too many samples in flight");

endmodule

bind kweighted_sliding_mean_square kwsms_checker u_kwsms_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.window_sum      (window_sum),
	.weighted_sample (weighted_sample)
);

FILE: tb/kweighted_sliding_mean_square_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kweighted_sliding_mean_square_tb
// Self-checking bench for the K-weighting filter pair and windowed square sum.
// ----------------------------------------------------------------------------
// A scoreboard object mirrors both biquads, the square ring and the running
// sum, and predicts one result per input transfer. Results are checked in
// order, field by field. The run steps through several register settings:
// reset values, window of one and of zero, the longest window, full-scale
// taps that drive the stages into saturation, and random taps and windows.
// ----------------------------------------------------------------------------
module kweighted_sliding_mean_square_tb;
	import kwsms_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000; // covers the ring clear after reset
	localparam int SETTLE_CYCLES  = 24;

	// mirror of the filter chain and window sum
	class loudness_scoreboard;
		logic signed [COEF_W-1:0]      taps [8];
		logic [WLEN_W-1:0]             wlen;
		logic signed [SAMPLE_BITS-1:0] hist [2][4];
		logic [SQ_W-1:0]               squares [RING_DEPTH];
		logic [SUM_W-1:0]              sum;
		logic [PTR_W-1:0]              wptr;
		logic [SUM_W-1:0]              want_sum [$];
		logic signed [SAMPLE_BITS-1:0] want_sample [$];
		int                            errors;
		int                            checked;

		function new();
			taps[REG_SHELF_B0]    = 412081942;
			taps[REG_SHELF_B1]    = -722546693;
			taps[REG_SHELF_B2]    = 321691120;
			taps[REG_SHELF_A1]    = -453832900;
			taps[REG_SHELF_A2]    = 196623809;
			taps[REG_HIGHPASS_A1] = -534199295;
			taps[REG_HIGHPASS_A2] = 265770496;
			wlen = 19200;
			foreach (hist[s, k]) hist[s][k] = '0;
			foreach (squares[k]) squares[k] = '0;
			sum = '0;
			wptr = '0;
			errors = 0;
			checked = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] d);
			if (idx == REG_WINDOW_LENGTH) begin
				wlen = d[WLEN_W-1:0];
				sum = '0; // window write restarts the sum, ring kept
			end else begin
				taps[idx] = d;
			end
		endfunction

		// one direct-form-I biquad, rounded half up and saturated
		function logic signed [SAMPLE_BITS-1:0] biquad(int s, logic signed [SAMPLE_BITS-1:0] x,
				logic signed [COEF_W-1:0] b0, b1, b2, a1, a2);
			longint acc;
			longint r;
			acc = longint'(b0) * longint'(x) + longint'(b1) * longint'(hist[s][0])
				+ longint'(b2) * longint'(hist[s][1]) - longint'(a1) * longint'(hist[s][2])
				- longint'(a2) * longint'(hist[s][3]);
			r = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			if (r > 8388607) r = 8388607;
			if (r < -8388608) r = -8388608;
			hist[s][1] = hist[s][0];
			hist[s][0] = x;
			hist[s][3] = hist[s][2];
			hist[s][2] = r[SAMPLE_BITS-1:0];
			return r[SAMPLE_BITS-1:0];
		endfunction

		function void note_sample(logic signed [SAMPLE_BITS-1:0] x);
			logic signed [SAMPLE_BITS-1:0] s1, s2;
			logic [SQ_W-1:0]               sq;
			logic [PTR_W-1:0]              rd;
			s1 = biquad(0, x, taps[REG_SHELF_B0], taps[REG_SHELF_B1], taps[REG_SHELF_B2],
				taps[REG_SHELF_A1], taps[REG_SHELF_A2]);
			s2 = biquad(1, s1, HP_B0, HP_B1, HP_B2, taps[REG_HIGHPASS_A1],
				taps[REG_HIGHPASS_A2]);
			sq = SQ_W'(longint'(s2) * longint'(s2));
			squares[wptr] = sq;
			rd = wptr - PTR_W'(wlen); // ring depth is a power of two
			sum = sum - SUM_W'(squares[rd]) + SUM_W'(sq);
			wptr = wptr + 1'b1;
			want_sum.push_back(sum);
			want_sample.push_back(s2);
		endfunction

		function void check_result(logic [SUM_W-1:0] got_sum,
				logic signed [SAMPLE_BITS-1:0] got_sample);
			logic [SUM_W-1:0]              es;
			logic signed [SAMPLE_BITS-1:0] ew;
			if (want_sum.size() == 0) begin
				$display("%0t: unexpected result sum=%0d sample=%0d", $time, got_sum,
					got_sample);
				errors++;
				return;
			end
			es = want_sum.pop_front();
			ew = want_sample.pop_front();
			checked++;
			if (got_sum !== es) begin
				$display("%0t: window_sum expected %0d actual %0d", $time, es, got_sum);
				errors++;
			end
			if (got_sample !== ew) begin
				$display("%0t: weighted_sample expected %0d actual %0d", $time, ew,
					got_sample);
				errors++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [CFG_IDX_W-1:0]          cfg_index;
	logic [CFG_DATA_W-1:0]         cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic signed [SAMPLE_BITS-1:0] audio_in;
	logic                          out_valid;
	logic                          out_stall;
	logic [SUM_W-1:0]              window_sum;
	logic signed [SAMPLE_BITS-1:0] weighted_sample;

	loudness_scoreboard sb;
	bit steady;       // no random idling on either side
	bit hold_request; // asks the receiver for a long stall
	int hold_left;
	int sent;
	int idle_cycles;

	kweighted_sliding_mean_square uut (.*);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall = 1'b1;
		end else begin
			out_stall = !steady && ($urandom_range(99) < 22);
		end
	end

	// result transfers, sampled before the edge updates anything
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(window_sum, weighted_sample);
	end

	// watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_cfg(reg_idx_t idx, logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// offer one sample and hold it until the transfer happens
	task automatic send_sample(logic signed [SAMPLE_BITS-1:0] x);
		while (!steady && $urandom_range(99) < 22) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		audio_in = x;
		do @(posedge clk); while (in_stall);
		sb.note_sample(x);
		sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// sender pause: everything back, then let the engine settle
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.want_sum.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55) return SAMPLE_BITS'($urandom());
		if (r < 80) return SAMPLE_BITS'(int'($urandom_range(4095)) - 2048);
		if (r < 90) return SAMPLE_BITS'(8388607);
		return SAMPLE_BITS'(-8388608);
	endfunction

	task automatic run_random(int n);
		repeat (n) send_sample(pick_sample());
	endtask

	initial begin
		logic signed [SAMPLE_BITS-1:0] directed [$];
		sb = new();
		steady = 1'b0;
		hold_request = 1'b0;
		hold_left = 0;
		sent = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		audio_in = '0;
		out_stall = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, impulses and steps at reset settings
		directed = '{0, 8388607, -8388608, 1, -1, 0, 0, 8388607, 8388607, 8388607,
			-8388608, -8388608, -8388608, 8388607, -8388608, 8388607, -8388608,
			4660, -4660, 0};
		foreach (directed[k]) send_sample(directed[k]);
		drain();

		// window of one: each update swaps the previous square for the latest; no idling here
		write_cfg(REG_WINDOW_LENGTH, 1);
		steady = 1'b1;
		run_random(150);
		steady = 1'b0;
		drain();

		// window of zero keeps the sum; receiver holds off while input fills
		write_cfg(REG_WINDOW_LENGTH, 0);
		hold_request = 1'b1;
		run_random(60);
		drain();

		// longest window with full-scale taps to saturate both stages
		write_cfg(REG_WINDOW_LENGTH, 32767);
		write_cfg(REG_SHELF_B0, 32'h7fffffff);
		write_cfg(REG_SHELF_B1, 32'h80000000);
		write_cfg(REG_SHELF_B2, 32'h7fffffff);
		write_cfg(REG_SHELF_A1, 32'h80000000);
		write_cfg(REG_SHELF_A2, 32'h7fffffff);
		write_cfg(REG_HIGHPASS_A1, 32'h7fffffff);
		write_cfg(REG_HIGHPASS_A2, 32'h80000000);
		run_random(100);
		drain();

		// random taps and windows, short windows favored
		for (int ph = 0; ph < 7; ph++) begin
			case ($urandom_range(3))
				0: write_cfg(REG_WINDOW_LENGTH, $urandom_range(1, 8));
				1: write_cfg(REG_WINDOW_LENGTH, $urandom_range(1, 300));
				2: write_cfg(REG_WINDOW_LENGTH, $urandom_range(32767));
				default: write_cfg(REG_WINDOW_LENGTH, 32767);
			endcase
			for (int r = REG_SHELF_B0; r <= REG_HIGHPASS_A2; r++) begin
				if (ph % 2 == 0)
					write_cfg(reg_idx_t'(r), $urandom());
				else
					write_cfg(reg_idx_t'(r), $urandom_range(32'h1fffffff) - 32'h10000000);
			end
			run_random(110);
			drain();
		end

		$display("Covered %0d samples, %0d results checked, windows 0/1/max and random,",
			sent, sb.checked);
		$display("saturating and random filter taps, long output hold-off.");
		if (sb.errors == 0 && sb.want_sum.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/kwsms_pkg.sv
rtl/kwsms_front.sv
rtl/kwsms_back.sv
rtl/kweighted_sliding_mean_square.sv
rtl/kwsms_checker.sv
tb/kweighted_sliding_mean_square_tb.sv
